FILE: hdl/ewtd_pkg.sv
// Package for the encoded-word text decoder: encoding codes, character
// constants and the hex and Base64 character classifiers.
// No dependencies.
package ewtd_pkg;

  typedef enum logic {
    EncQ      = 1'b0,
    EncBase64 = 1'b1
  } encoding_e;

  localparam int OutputLimitDefault = 2047;

  localparam int QueueDepth = 4;
  localparam int MaxResults = 3;

  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendEq    = 2'd1;
  localparam logic [1:0] PendDigit = 2'd2;

  localparam logic [7:0] CharEq         = 8'h3D;
  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharSpace      = 8'h20;
  localparam logic [7:0] CharPlus       = 8'h2B;
  localparam logic [7:0] CharSlash      = 8'h2F;

  typedef logic [7:0] byte_t;

  function automatic logic is_hex(input byte_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input byte_t c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    return v[3:0];
  endfunction

  function automatic logic is_b64(input byte_t c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CharPlus || c == CharSlash;
  endfunction

  function automatic logic [5:0] b64_val(input byte_t c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h47;
    else if (c >= 8'h30 && c <= 8'h39) v = c + 8'h04;
    else if (c == CharPlus) v = 8'd62;
    else if (c == CharSlash) v = 8'd63;
    return v[5:0];
  endfunction

endpackage

FILE: hdl/encoded_word_text_decoder.sv
// Encoded-word text decoder top level: Q and Base64 decoding with a result queue.
// Depends on ewtd_pkg.
//
// One text byte is taken per cycle unless in_stall_o is high; its decoded
// bytes are registered in the result queue, which gives one result beat per
// cycle unless out_stall_i is high. A byte that yields at most one result
// then sustains one item per cycle; a byte that yields two or three results
// (a broken Q escape, or a flush at word end) holds the input while the
// four-entry result queue drains. The input is taken while one earlier result
// still waits. Output of a word stops at OUTPUT_LIMIT bytes; the last byte
// of a word always yields an end_of_word_o result, empty if no byte is left.
module encoded_word_text_decoder #(
  parameter int OUTPUT_LIMIT = ewtd_pkg::OutputLimitDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       last_of_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_word_o
);

  localparam int CntW = $clog2(OUTPUT_LIMIT + 1);
  localparam int HeadW = CntW + 2;
  localparam int Depth = ewtd_pkg::QueueDepth;
  localparam int MaxRes = ewtd_pkg::MaxResults;

  ewtd_pkg::encoding_e enc_q;

  logic [1:0]       pend_cnt_q, pend_cnt_d;
  logic [7:0]       pend_digit_q, pend_digit_d;
  logic [13:0]      acc_q, acc_d;
  logic [2:0]       bits_q, bits_d;
  logic [CntW-1:0]  emit_cnt_q, emit_cnt_d;

  logic [7:0]       qb_q [Depth];
  logic             qv_q [Depth];
  logic             qe_q [Depth];
  logic [7:0]       qb_d [Depth];
  logic             qv_d [Depth];
  logic             qe_d [Depth];
  logic [2:0]       occ_q, occ_d;

  logic [7:0]       cand [MaxRes];
  logic [1:0]       n_cand;
  logic [1:0]       n_take;
  logic [1:0]       n_res;
  logic [HeadW-1:0] headroom;
  logic             pop;
  logic             accept;
  logic [2:0]       base;
  logic             do_plain;
  logic [13:0]      acc_n;
  logic [3:0]       bits_sum;
  logic [1:0]       widx;

  assign pop         = out_valid_o && !out_stall_i;
  assign base        = occ_q - {2'b00, pop};
  assign in_stall_o  = base > 3'd1;
  assign accept      = in_valid_i && !in_stall_o;

  assign out_valid_o   = occ_q != 3'd0;
  assign out_byte_o    = qb_q[0];
  assign byte_valid_o  = qv_q[0];
  assign end_of_word_o = qe_q[0];

  always_comb begin
    pend_cnt_d   = pend_cnt_q;
    pend_digit_d = pend_digit_q;
    acc_d        = acc_q;
    bits_d       = bits_q;
    n_cand       = 2'd0;
    do_plain     = 1'b0;
    acc_n        = {acc_q[7:0], ewtd_pkg::b64_val(text_byte_i)};
    bits_sum     = {1'b0, bits_q} + 4'd6;
    for (int j = 0; j < MaxRes; j++) cand[j] = 8'h00;

    unique case (enc_q)
      ewtd_pkg::EncQ: begin
        priority if (pend_cnt_q == ewtd_pkg::PendEq) begin
          if (ewtd_pkg::is_hex(text_byte_i)) begin
            pend_digit_d = text_byte_i;
            pend_cnt_d   = ewtd_pkg::PendDigit;
          end else begin
            pend_cnt_d   = ewtd_pkg::PendNone;
            cand[n_cand] = ewtd_pkg::CharEq;
            n_cand       = n_cand + 2'd1;
            do_plain     = 1'b1;
          end
        end else if (pend_cnt_q == ewtd_pkg::PendDigit) begin
          pend_cnt_d = ewtd_pkg::PendNone;
          if (ewtd_pkg::is_hex(text_byte_i)) begin
            cand[n_cand] = {ewtd_pkg::hex_val(pend_digit_q), ewtd_pkg::hex_val(text_byte_i)};
            n_cand       = n_cand + 2'd1;
          end else begin
            cand[n_cand] = ewtd_pkg::CharEq;
            n_cand       = n_cand + 2'd1;
            cand[n_cand] = pend_digit_q;
            n_cand       = n_cand + 2'd1;
            do_plain     = 1'b1;
          end
        end else begin
          pend_cnt_d = ewtd_pkg::PendNone;
          do_plain   = 1'b1;
        end

        if (do_plain) begin
          priority if (text_byte_i == ewtd_pkg::CharEq) begin
            pend_cnt_d = ewtd_pkg::PendEq;
          end else if (text_byte_i == ewtd_pkg::CharUnderscore) begin
            cand[n_cand] = ewtd_pkg::CharSpace;
            n_cand       = n_cand + 2'd1;
          end else begin
            cand[n_cand] = text_byte_i;
            n_cand       = n_cand + 2'd1;
          end
        end

        if (last_of_word_i) begin
          priority if (pend_cnt_d == ewtd_pkg::PendEq) begin
            cand[n_cand] = ewtd_pkg::CharEq;
            n_cand       = n_cand + 2'd1;
          end else if (pend_cnt_d == ewtd_pkg::PendDigit) begin
            cand[n_cand] = ewtd_pkg::CharEq;
            n_cand       = n_cand + 2'd1;
            cand[n_cand] = pend_digit_d;
            n_cand       = n_cand + 2'd1;
          end else begin
            n_cand = n_cand;
          end
        end
      end
      ewtd_pkg::EncBase64: begin
        if (ewtd_pkg::is_b64(text_byte_i)) begin
          acc_d = acc_n;
          if (bits_sum[3]) begin
            bits_d  = bits_sum[2:0];
            cand[0] = 8'(acc_n >> bits_sum[2:0]);
            n_cand  = 2'd1;
          end else begin
            bits_d = bits_sum[2:0];
          end
        end
      end
      default: begin
        n_cand = 2'd0;
      end
    endcase

    headroom = HeadW'(OUTPUT_LIMIT) - HeadW'(emit_cnt_q);
    if (headroom >= HeadW'(n_cand)) n_take = n_cand;
    else n_take = headroom[1:0];

    if (last_of_word_i && n_take == 2'd0) n_res = 2'd1;
    else n_res = n_take;

    emit_cnt_d = emit_cnt_q + CntW'(n_take);

    if (last_of_word_i) begin
      pend_cnt_d   = ewtd_pkg::PendNone;
      pend_digit_d = 8'h00;
      acc_d        = 14'd0;
      bits_d       = 3'd0;
      emit_cnt_d   = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < Depth - 1; i++) begin
      if (pop) begin
        qb_d[i] = qb_q[i+1];
        qv_d[i] = qv_q[i+1];
        qe_d[i] = qe_q[i+1];
      end else begin
        qb_d[i] = qb_q[i];
        qv_d[i] = qv_q[i];
        qe_d[i] = qe_q[i];
      end
    end
    qb_d[Depth-1] = qb_q[Depth-1];
    qv_d[Depth-1] = qv_q[Depth-1];
    qe_d[Depth-1] = qe_q[Depth-1];
    widx  = 2'd0;
    occ_d = base;
    if (accept) begin
      for (int j = 0; j < MaxRes; j++) begin
        if (2'(j) < n_res) begin
          widx       = base[1:0] + 2'(j);
          qb_d[widx] = (2'(j) < n_take) ? cand[j] : 8'h00;
          qv_d[widx] = 2'(j) < n_take;
          qe_d[widx] = last_of_word_i && (2'(j) == n_res - 2'd1);
        end
      end
      occ_d = base + {1'b0, n_res};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q        <= ewtd_pkg::EncQ;
      pend_cnt_q   <= ewtd_pkg::PendNone;
      pend_digit_q <= 8'h00;
      acc_q        <= 14'd0;
      bits_q       <= 3'd0;
      emit_cnt_q   <= '0;
      occ_q        <= 3'd0;
    end else begin
      if (cfg_we_i) begin
        enc_q <= ewtd_pkg::encoding_e'(cfg_wdata_i);
      end
      if (accept) begin
        pend_cnt_q   <= pend_cnt_d;
        pend_digit_q <= pend_digit_d;
        acc_q        <= acc_d;
        bits_q       <= bits_d;
        emit_cnt_q   <= emit_cnt_d;
      end
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      qb_q[i] <= qb_d[i];
      qv_q[i] <= qv_d[i];
      qe_q[i] <= qe_d[i];
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 3'(Depth))
    else $error("result queue overfilled");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_of_word_i |=> out_valid_o)
    else $error("word end produced no result");

  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> end_of_word_o && out_byte_o == 8'h00)
    else $error("empty result not marked as word end");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HeadW'(emit_cnt_q) <= HeadW'(OUTPUT_LIMIT))
    else $error("emitted count beyond limit");

endmodule
